FILE: sv/baip_pkg.sv
// Package: beat types and constants for the BAM index chunk offset parser.
package baip_pkg;

  localparam logic [1:0] KIND_CHUNK = 2'd0;
  localparam logic [1:0] KIND_ERROR = 2'd1;
  localparam logic [1:0] KIND_DONE  = 2'd2;

  localparam logic [7:0] MAGIC_0 = 8'h42;
  localparam logic [7:0] MAGIC_1 = 8'h41;
  localparam logic [7:0] MAGIC_2 = 8'h49;
  localparam logic [7:0] MAGIC_3 = 8'h01;

  localparam int unsigned BLOCK_SHIFT = 16;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
  } item_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [30:0]        ref_index;
    logic signed [31:0] bin_id;
    logic [47:0]        start_block;
    logic [47:0]        end_block;
    logic [15:0]        start_within;
    logic [15:0]        end_within;
  } result_t;

endpackage

FILE: sv/bam_index_chunk_offset_parser_core.sv
// BAM index chunk offset parser: byte-serial BAI walker emitting chunk records.
// Latency: a result is valid in the cycle after the byte that completes it is taken.
// Throughput: one byte per cycle; a held result stalls intake only while result_ready is low.
// The single result register is the only buffer between the two sides.
// Reset (rst, synchronous): parser idle, all counters clear, no result pending.
module bam_index_chunk_offset_parser_core
  import baip_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_ready,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  localparam logic [3:0] PH_IDLE   = 4'd0;
  localparam logic [3:0] PH_MAGIC  = 4'd1;
  localparam logic [3:0] PH_NREF   = 4'd2;
  localparam logic [3:0] PH_NBIN   = 4'd3;
  localparam logic [3:0] PH_BINID  = 4'd4;
  localparam logic [3:0] PH_NCHUNK = 4'd5;
  localparam logic [3:0] PH_CSTART = 4'd6;
  localparam logic [3:0] PH_CEND   = 4'd7;
  localparam logic [3:0] PH_NINTV  = 4'd8;
  localparam logic [3:0] PH_INTV   = 4'd9;
  localparam logic [3:0] PH_DONE   = 4'd10;

  logic [3:0]  phase, phase_next;
  logic [2:0]  byte_in_field, byte_in_field_next;
  logic [63:0] field_shift, field_shift_next;
  logic [30:0] refs_left, refs_left_next;
  logic [30:0] bins_left, bins_left_next;
  logic [30:0] chunks_left, chunks_left_next;
  logic [30:0] intervals_left, intervals_left_next;
  logic [30:0] current_ref, current_ref_next;
  logic [31:0] current_bin, current_bin_next;
  logic [63:0] held_start, held_start_next;

  logic        accept;
  logic        emit;
  logic [1:0]  emit_kind;
  logic [63:0] end_value;
  result_t     result_next;

  logic [3:0]  ph;
  logic [2:0]  bif;
  logic [63:0] fs;
  logic [63:0] fs_in;
  logic        long_field;
  logic        field_done;
  logic [63:0] v;
  logic [31:0] v32;
  logic [30:0] cnt;
  logic [7:0]  magic_byte;
  logic [30:0] refs_dec, bins_dec, chunks_dec, intervals_dec;

  assign item_ready = !result_valid || result_ready;
  assign accept     = item_valid && item_ready;

  always_comb begin
    ph  = item.first_byte ? PH_MAGIC : phase;
    bif = item.first_byte ? 3'd0 : byte_in_field;
    fs  = item.first_byte ? 64'd0 : field_shift;

    fs_in      = {item.data_byte, fs[63:8]};
    long_field = (ph == PH_CSTART) || (ph == PH_CEND) || (ph == PH_INTV);
    field_done = long_field ? (bif == 3'd7) : (bif == 3'd3);
    v          = long_field ? fs_in : {32'd0, fs_in[63:32]};
    v32        = v[31:0];
    cnt        = v32[31] ? 31'd0 : v32[30:0];

    refs_dec      = refs_left - 31'd1;
    bins_dec      = bins_left - 31'd1;
    chunks_dec    = chunks_left - 31'd1;
    intervals_dec = intervals_left - 31'd1;

    case (bif[1:0])
      2'd0:    magic_byte = MAGIC_0;
      2'd1:    magic_byte = MAGIC_1;
      2'd2:    magic_byte = MAGIC_2;
      default: magic_byte = MAGIC_3;
    endcase

    phase_next          = ph;
    byte_in_field_next  = bif;
    field_shift_next    = fs;
    refs_left_next      = item.first_byte ? 31'd0 : refs_left;
    bins_left_next      = item.first_byte ? 31'd0 : bins_left;
    chunks_left_next    = item.first_byte ? 31'd0 : chunks_left;
    intervals_left_next = item.first_byte ? 31'd0 : intervals_left;
    current_ref_next    = item.first_byte ? 31'd0 : current_ref;
    current_bin_next    = item.first_byte ? 32'd0 : current_bin;
    held_start_next     = item.first_byte ? 64'd0 : held_start;
    emit                = 1'b0;
    emit_kind           = KIND_CHUNK;
    end_value           = v;

    if (ph == PH_MAGIC) begin
      if (item.data_byte != magic_byte) begin
        phase_next         = PH_DONE;
        byte_in_field_next = 3'd0;
        emit               = 1'b1;
        emit_kind          = KIND_ERROR;
      end else if (bif == 3'd3) begin
        byte_in_field_next = 3'd0;
        phase_next         = PH_NREF;
      end else begin
        byte_in_field_next = bif + 3'd1;
      end
    end else if (ph != PH_IDLE && ph != PH_DONE) begin
      if (!field_done) begin
        field_shift_next   = fs_in;
        byte_in_field_next = bif + 3'd1;
      end else begin
        field_shift_next   = 64'd0;
        byte_in_field_next = 3'd0;
        unique case (ph)
          PH_NREF: begin
            refs_left_next   = cnt;
            current_ref_next = 31'd0;
            if (cnt == 31'd0) begin
              phase_next = PH_DONE;
              emit       = 1'b1;
              emit_kind  = KIND_DONE;
            end else begin
              phase_next = PH_NBIN;
            end
          end
          PH_NBIN: begin
            bins_left_next = cnt;
            phase_next     = (cnt == 31'd0) ? PH_NINTV : PH_BINID;
          end
          PH_BINID: begin
            current_bin_next = v32;
            phase_next       = PH_NCHUNK;
          end
          PH_NCHUNK: begin
            chunks_left_next = cnt;
            if (cnt == 31'd0) begin
              bins_left_next = bins_dec;
              phase_next     = (bins_dec == 31'd0) ? PH_NINTV : PH_BINID;
            end else begin
              phase_next = PH_CSTART;
            end
          end
          PH_CSTART: begin
            held_start_next = v;
            phase_next      = PH_CEND;
          end
          PH_CEND: begin
            emit             = 1'b1;
            emit_kind        = KIND_CHUNK;
            chunks_left_next = chunks_dec;
            if (chunks_dec == 31'd0) begin
              bins_left_next = bins_dec;
              phase_next     = (bins_dec == 31'd0) ? PH_NINTV : PH_BINID;
            end else begin
              phase_next = PH_CSTART;
            end
          end
          PH_NINTV, PH_INTV: begin
            intervals_left_next = (ph == PH_NINTV) ? cnt : intervals_dec;
            if ((ph == PH_NINTV) ? (cnt == 31'd0) : (intervals_dec == 31'd0)) begin
              refs_left_next   = refs_dec;
              current_ref_next = current_ref + 31'd1;
              if (refs_dec == 31'd0) begin
                phase_next = PH_DONE;
                emit       = 1'b1;
                emit_kind  = KIND_DONE;
              end else begin
                phase_next = PH_NBIN;
              end
            end else begin
              phase_next = PH_INTV;
            end
          end
          default: begin
            phase_next = PH_IDLE;
          end
        endcase
      end
    end
  end

  always_comb begin
    result_next      = '0;
    result_next.kind = emit_kind;
    if (emit_kind == KIND_CHUNK) begin
      result_next.ref_index    = current_ref;
      result_next.bin_id       = current_bin;
      result_next.start_block  = held_start[63:BLOCK_SHIFT];
      result_next.end_block    = end_value[63:BLOCK_SHIFT];
      result_next.start_within = held_start[BLOCK_SHIFT-1:0];
      result_next.end_within   = end_value[BLOCK_SHIFT-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      byte_in_field  <= 3'd0;
      field_shift    <= 64'd0;
      refs_left      <= 31'd0;
      bins_left      <= 31'd0;
      chunks_left    <= 31'd0;
      intervals_left <= 31'd0;
      current_ref    <= 31'd0;
      current_bin    <= 32'd0;
      held_start     <= 64'd0;
      result_valid   <= 1'b0;
    end else begin
      if (accept) begin
        phase          <= phase_next;
        byte_in_field  <= byte_in_field_next;
        field_shift    <= field_shift_next;
        refs_left      <= refs_left_next;
        bins_left      <= bins_left_next;
        chunks_left    <= chunks_left_next;
        intervals_left <= intervals_left_next;
        current_ref    <= current_ref_next;
        current_bin    <= current_bin_next;
        held_start     <= held_start_next;
      end
      if (accept && emit) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      result <= result_next;
    end
  end

endmodule

FILE: tb/sv/bam_index_chunk_offset_parser_checker.sv
// Checker for the BAM index parser: predicts result beats from accepted bytes and compares.
module bam_index_chunk_offset_parser_checker
  import baip_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  input  logic    item_ready,
  input  item_t   item,
  input  logic    result_valid,
  input  logic    result_ready,
  input  result_t result,
  output int      fail_count,
  output int      pending
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_MAGIC, ST_NREF, ST_NBIN, ST_BINID, ST_NCHUNK,
    ST_CSTART, ST_CEND, ST_NINTV, ST_INTV, ST_DONE
  } walk_state_t;

  localparam logic [31:0] MAGIC_WORD = {MAGIC_3, MAGIC_2, MAGIC_1, MAGIC_0};

  walk_state_t walk_state;
  logic [2:0]  field_pos;
  logic [63:0] field_acc;
  logic [31:0] refs_todo;
  logic [31:0] bins_todo;
  logic [31:0] chunks_todo;
  logic [31:0] intv_todo;
  logic [31:0] ref_num;
  logic [31:0] bin_num;
  logic [63:0] chunk_start;

  result_t expected_records[$];
  result_t want;
  result_t oldest;
  bit      hit;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] exp_v);
    if (fail_count < 50) begin
      $display("mismatch %s: got %h expected %h", what, got, exp_v);
    end
    fail_count++;
  endtask

  task automatic clear_walker();
    walk_state  = ST_IDLE;
    field_pos   = '0;
    field_acc   = '0;
    refs_todo   = '0;
    bins_todo   = '0;
    chunks_todo = '0;
    intv_todo   = '0;
    ref_num     = '0;
    bin_num     = '0;
    chunk_start = '0;
  endtask

  // negative counts read as zero
  function automatic logic [31:0] count_of(input logic [63:0] v);
    return v[31] ? 32'd0 : v[31:0];
  endfunction

  task automatic close_index();
    walk_state = ST_DONE;
    hit        = 1'b1;
    want       = '0;
    want.kind  = KIND_DONE;
  endtask

  task automatic next_ref();
    refs_todo--;
    ref_num++;
    if (refs_todo == 0) close_index();
    else walk_state = ST_NBIN;
  endtask

  task automatic next_bin();
    bins_todo--;
    walk_state = (bins_todo == 0) ? ST_NINTV : ST_BINID;
  endtask

  task automatic walk_byte(input item_t it);
    int unsigned len;
    logic [63:0] v;
    hit  = 1'b0;
    want = '0;
    if (it.first_byte) begin
      clear_walker();
      walk_state = ST_MAGIC;
    end
    if (walk_state == ST_IDLE || walk_state == ST_DONE) return;
    if (walk_state == ST_MAGIC) begin
      if (it.data_byte != MAGIC_WORD[8 * field_pos[1:0] +: 8]) begin
        walk_state = ST_DONE;
        field_pos  = '0;
        hit        = 1'b1;
        want.kind  = KIND_ERROR;
      end else if (field_pos == 3'd3) begin
        field_pos  = '0;
        walk_state = ST_NREF;
      end else begin
        field_pos++;
      end
      return;
    end
    len = (walk_state == ST_CSTART || walk_state == ST_CEND || walk_state == ST_INTV) ? 8 : 4;
    field_acc |= 64'(it.data_byte) << (8 * field_pos);
    field_pos++;
    if (field_pos != len[2:0]) return;
    v         = field_acc;
    field_acc = '0;
    field_pos = '0;
    case (walk_state)
      ST_NREF: begin
        refs_todo = count_of(v);
        ref_num   = '0;
        if (refs_todo == 0) close_index();
        else walk_state = ST_NBIN;
      end
      ST_NBIN: begin
        bins_todo  = count_of(v);
        walk_state = (bins_todo == 0) ? ST_NINTV : ST_BINID;
      end
      ST_BINID: begin
        bin_num    = v[31:0];
        walk_state = ST_NCHUNK;
      end
      ST_NCHUNK: begin
        chunks_todo = count_of(v);
        if (chunks_todo == 0) next_bin();
        else walk_state = ST_CSTART;
      end
      ST_CSTART: begin
        chunk_start = v;
        walk_state  = ST_CEND;
      end
      ST_CEND: begin
        hit               = 1'b1;
        want.kind         = KIND_CHUNK;
        want.ref_index    = ref_num[30:0];
        want.bin_id       = bin_num;
        want.start_block  = 48'(chunk_start >> BLOCK_SHIFT);
        want.end_block    = 48'(v >> BLOCK_SHIFT);
        want.start_within = chunk_start[15:0];
        want.end_within   = v[15:0];
        chunks_todo--;
        if (chunks_todo == 0) next_bin();
        else walk_state = ST_CSTART;
      end
      ST_NINTV: begin
        intv_todo = count_of(v);
        if (intv_todo == 0) next_ref();
        else walk_state = ST_INTV;
      end
      ST_INTV: begin
        intv_todo--;
        if (intv_todo == 0) next_ref();
      end
      default: walk_state = ST_IDLE;
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_walker();
      expected_records.delete();
      fail_count = 0;
    end else begin
      if (item_valid && item_ready) begin
        walk_byte(item);
        if (hit) expected_records.push_back(want);
      end
      if (result_valid && result_ready) begin
        if (expected_records.size() == 0) begin
          report("unexpected beat, kind", 64'(result.kind), '0);
        end else begin
          oldest = expected_records.pop_front();
          if (result.kind !== oldest.kind)
            report("kind", 64'(result.kind), 64'(oldest.kind));
          if (result.ref_index !== oldest.ref_index)
            report("ref_index", 64'(result.ref_index), 64'(oldest.ref_index));
          if (result.bin_id !== oldest.bin_id)
            report("bin_id", 64'(result.bin_id), 64'(oldest.bin_id));
          if (result.start_block !== oldest.start_block)
            report("start_block", 64'(result.start_block), 64'(oldest.start_block));
          if (result.end_block !== oldest.end_block)
            report("end_block", 64'(result.end_block), 64'(oldest.end_block));
          if (result.start_within !== oldest.start_within)
            report("start_within", 64'(result.start_within), 64'(oldest.start_within));
          if (result.end_within !== oldest.end_within)
            report("end_within", 64'(result.end_within), 64'(oldest.end_within));
        end
      end
    end
    pending <= expected_records.size();
  end

endmodule

FILE: tb/sv/bam_index_chunk_offset_parser_core_tb.sv
// Testbench top for the BAM index parser: byte stimulus, back-pressure, watchdog and verdict.
module bam_index_chunk_offset_parser_core_tb;
  import baip_pkg::*;

  localparam int STALL_LIMIT    = 2000;
  localparam int TARGET_ITEMS   = 400;
  localparam int STEADY_LEN     = 150;

  localparam logic [31:0] MAGIC_WORD = {MAGIC_3, MAGIC_2, MAGIC_1, MAGIC_0};

  logic    clk          = 1'b0;
  logic    rst          = 1'b1;
  logic    item_valid   = 1'b0;
  logic    item_ready;
  item_t   item         = '0;
  logic    result_valid;
  logic    result_ready = 1'b0;
  result_t result;
  logic    steady       = 1'b0;

  int fail_count;
  int pending;
  int idle_cycles   = 0;
  int live_items    = 0;

  item_t stim_q[$];

  bam_index_chunk_offset_parser_core uut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  bam_index_chunk_offset_parser_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    result_ready <= steady || ($urandom_range(0, 99) >= 27);
  end

  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL bam_index_chunk_offset_parser_core");
      $finish;
    end
  end

  task automatic push_byte(input logic [7:0] data, input logic fb);
    stim_q.push_back({data, fb});
    live_items++;
  endtask

  task automatic push_word(input logic [31:0] w);
    for (int k = 0; k < 4; k++) push_byte(w[8 * k +: 8], 1'b0);
  endtask

  task automatic push_qword(input logic [63:0] w);
    for (int k = 0; k < 8; k++) push_byte(w[8 * k +: 8], 1'b0);
  endtask

  task automatic push_magic();
    push_byte(MAGIC_0, 1'b1);
    push_byte(MAGIC_1, 1'b0);
    push_byte(MAGIC_2, 1'b0);
    push_byte(MAGIC_3, 1'b0);
  endtask

  function automatic logic [31:0] rand_count(input int unsigned hi);
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000 | $urandom;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom_range(0, hi);
    endcase
  endfunction

  function automatic logic [63:0] rand_offset();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [31:0] rand_bin();
    case ($urandom_range(0, 7))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return '1;
      3:       return '0;
      default: return $urandom;
    endcase
  endfunction

  // well-formed index with random content; cut drops its tail so the next file restarts mid-parse
  task automatic add_index(input bit cut);
    int first, nref, nbin, nchunk, nintv, keep, ri, bi, ci, ii;
    logic [31:0] c;
    first = stim_q.size();
    push_magic();
    c = rand_count(3);
    push_word(c);
    nref = c[31] ? 0 : int'(c);
    for (ri = 0; ri < nref; ri++) begin
      c = rand_count(3);
      push_word(c);
      nbin = c[31] ? 0 : int'(c);
      for (bi = 0; bi < nbin; bi++) begin
        push_word(rand_bin());
        c = rand_count(3);
        push_word(c);
        nchunk = c[31] ? 0 : int'(c);
        for (ci = 0; ci < nchunk; ci++) begin
          push_qword(rand_offset());
          push_qword(rand_offset());
        end
      end
      c = rand_count(2);
      push_word(c);
      nintv = c[31] ? 0 : int'(c);
      for (ii = 0; ii < nintv; ii++) push_qword({$urandom, $urandom});
    end
    if (cut) begin
      keep = $urandom_range(1, stim_q.size() - first - 1);
      while (stim_q.size() > first + keep) begin
        void'(stim_q.pop_back());
        live_items--;
      end
    end
  endtask

  initial begin
    int i, k, n, directed_end, pause_mid, steady_lo, paused_at;
    bit calm_now;

    // ignored while idle
    stim_q.push_back({8'h00, 1'b0});
    stim_q.push_back({8'hFF, 1'b0});
    // bad first magic byte, then a byte ignored after the error
    push_byte(8'h00, 1'b1);
    stim_q.push_back({MAGIC_0, 1'b0});
    // bad last magic byte
    push_byte(MAGIC_0, 1'b1);
    push_byte(MAGIC_1, 1'b0);
    push_byte(MAGIC_2, 1'b0);
    push_byte(8'h02, 1'b0);
    // no references, then a negative reference count
    push_magic();
    push_word(32'h0000_0000);
    push_magic();
    push_word(32'h8000_0000);
    directed_end = stim_q.size();

    while (live_items < TARGET_ITEMS) begin
      n = $urandom_range(0, 99);
      if (n < 65) begin
        add_index(1'b0);
      end else if (n < 75) begin
        add_index(1'b1);
      end else if (n < 85) begin
        k = $urandom_range(0, 3);
        for (int j = 0; j < k; j++) push_byte(MAGIC_WORD[8 * j +: 8], j == 0);
        push_byte(MAGIC_WORD[8 * k +: 8] ^ 8'($urandom_range(1, 255)), k == 0);
      end else if (n < 92) begin
        push_magic();
        push_word($urandom_range(0, 1) ? 32'h0 : (32'h8000_0000 | $urandom));
      end else begin
        k = $urandom_range(1, 4);
        for (int j = 0; j < k; j++) push_byte(8'($urandom), 1'($urandom_range(0, 1)));
      end
      // trailing bytes after a finished file are ignored
      if ((n < 65 || (n >= 75 && n < 92)) && $urandom_range(0, 99) < 30) begin
        k = $urandom_range(1, 4);
        for (int j = 0; j < k; j++) stim_q.push_back({8'($urandom), 1'b0});
      end
    end

    steady_lo = stim_q.size() / 3;
    pause_mid = (stim_q.size() * 2) / 3;
    paused_at = -1;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    i = 0;
    while (i < stim_q.size()) begin
      calm_now = (i >= steady_lo && i < steady_lo + STEADY_LEN);
      steady <= calm_now;
      if ((i == directed_end || i == pause_mid) && paused_at != i) begin
        item_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        paused_at = i;
      end else if (!calm_now && $urandom_range(0, 99) < 27) begin
        item_valid <= 1'b0;
        @(posedge clk);
      end else begin
        item_valid <= 1'b1;
        item       <= stim_q[i];
        @(posedge clk);
        while (!item_ready) @(posedge clk);
        i++;
      end
    end
    item_valid <= 1'b0;
    steady     <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (16) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS bam_index_chunk_offset_parser_core");
    end else begin
      $display("FAIL bam_index_chunk_offset_parser_core");
    end
    $finish;
  end

endmodule
